// File: rtl/calendar_date_offset_core_assert.svh
// Assertion macros used by the checker of the date offset core.
// Each check is sampled on i_clk and is off while i_rst_n is low.
`ifndef CALENDAR_DATE_OFFSET_CORE_ASSERT_SVH
`define CALENDAR_DATE_OFFSET_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDO_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdo check failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define CDO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdo check failed: next-cycle rule");

`endif

// File: rtl/cdo_pkg.sv
package cdo_pkg;

    localparam int unsigned MAX_SHIFT = 4095;

    localparam int unsigned W_MODE  = 3;
    localparam int unsigned W_DAY   = 5;
    localparam int unsigned W_MONTH = 4;
    localparam int unsigned W_YEAR  = 16;
    localparam int unsigned W_AMT   = 12;
    localparam int unsigned W_ALU   = W_YEAR + 1;
    localparam int unsigned W_REM   = 9;
    localparam int unsigned W_QUO   = 9;
    localparam int unsigned W_STEP  = 4;

    localparam logic [W_AMT-1:0]  C_MAX_SHIFT = W_AMT'(MAX_SHIFT);
    localparam logic [W_YEAR-1:0] C_YEAR_MAX  = {W_YEAR{1'b1}};
    localparam logic [W_YEAR-1:0] C_YEAR_MIN  = '0;
    localparam logic [W_ALU-1:0]  C_Y400      = W_ALU'(400);
    localparam logic [W_ALU-1:0]  C_M12       = W_ALU'(12);
    localparam logic [W_REM-1:0]  C_REM_LAST  = W_REM'(399);
    localparam logic [W_STEP-1:0] C_RED_TOP   = W_STEP'(7);
    localparam logic [W_STEP-1:0] C_DIV_TOP   = W_STEP'(8);
    localparam logic [W_DAY-1:0]  C_DAY_FIRST = W_DAY'(1);
    localparam logic [W_DAY-1:0]  C_DAY_LAST  = W_DAY'(31);
    localparam logic [W_DAY-1:0]  C_MON_SPAN  = W_DAY'(12);

    // Operation codes
    localparam logic [W_MODE-1:0] MODE_ADD_DAYS   = 3'd0;
    localparam logic [W_MODE-1:0] MODE_SUB_DAYS   = 3'd1;
    localparam logic [W_MODE-1:0] MODE_ADD_MONTHS = 3'd2;
    localparam logic [W_MODE-1:0] MODE_SUB_MONTHS = 3'd3;
    localparam logic [W_MODE-1:0] MODE_ADD_YEARS  = 3'd4;
    localparam logic [W_MODE-1:0] MODE_SUB_YEARS  = 3'd5;

    localparam logic [W_MONTH-1:0] M_JAN = 4'd1;
    localparam logic [W_MONTH-1:0] M_FEB = 4'd2;
    localparam logic [W_MONTH-1:0] M_APR = 4'd4;
    localparam logic [W_MONTH-1:0] M_JUN = 4'd6;
    localparam logic [W_MONTH-1:0] M_SEP = 4'd9;
    localparam logic [W_MONTH-1:0] M_NOV = 4'd11;
    localparam logic [W_MONTH-1:0] M_DEC = 4'd12;

    typedef struct packed {
        logic [W_MODE-1:0]  mode;
        logic [W_DAY-1:0]   day;
        logic [W_MONTH-1:0] month;
        logic [W_YEAR-1:0]  year;
        logic [W_AMT-1:0]   amount;
    } t_req;

    typedef struct packed {
        logic [W_DAY-1:0]   day;
        logic [W_MONTH-1:0] month;
        logic [W_YEAR-1:0]  year;
        logic               err;
    } t_res;

    typedef struct packed {
        logic [W_ALU-1:0] a;
        logic [W_ALU-1:0] b;
        logic             sub;
    } t_alu_op;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

    // Leap test from the year mod 400; year zero is never leap.
    function automatic logic f_is_leap(input logic y_nz, input logic [1:0] y_lo,
                                       input logic [W_REM-1:0] rem);
        logic cent;
        cent = (rem == W_REM'(100)) || (rem == W_REM'(200)) || (rem == W_REM'(300));
        return y_nz && ((rem == '0) || (!cent && (y_lo == 2'd0)));
    endfunction

    function automatic logic [W_DAY-1:0] f_month_len(input logic [W_MONTH-1:0] m,
                                                     input logic leap);
        logic [W_DAY-1:0] len;
        case (m)
            M_FEB: len = leap ? W_DAY'(29) : W_DAY'(28);
            M_APR, M_JUN, M_SEP, M_NOV: len = W_DAY'(30);
            default: len = C_DAY_LAST;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/cdo_req_if.sv
interface cdo_req_if;
    logic                        valid;
    logic                        ready;
    logic [cdo_pkg::W_MODE-1:0]  mode;
    logic [cdo_pkg::W_DAY-1:0]   day_in;
    logic [cdo_pkg::W_MONTH-1:0] month_in;
    logic [cdo_pkg::W_YEAR-1:0]  year_in;
    logic [cdo_pkg::W_AMT-1:0]   amount;

    modport source (output valid, mode, day_in, month_in, year_in, amount, input ready);
    modport sink (input valid, mode, day_in, month_in, year_in, amount, output ready);
endinterface

// File: rtl/cdo_res_if.sv
interface cdo_res_if;
    logic                        valid;
    logic                        ready;
    logic [cdo_pkg::W_DAY-1:0]   day_out;
    logic [cdo_pkg::W_MONTH-1:0] month_out;
    logic [cdo_pkg::W_YEAR-1:0]  year_out;
    logic                        range_error;

    modport source (output valid, day_out, month_out, year_out, range_error, input ready);
    modport sink (input valid, day_out, month_out, year_out, range_error, output ready);
endinterface

// File: rtl/cdo_alu.sv
module cdo_alu (
    input  cdo_pkg::t_alu_op              i_op,
    output logic [cdo_pkg::W_ALU-1:0]     o_sum,
    output logic                          o_carry
);

    logic [cdo_pkg::W_ALU:0] w_sum;

    // Two's complement add or subtract; on subtract, carry set means a >= b.
    assign w_sum = {1'b0, i_op.a} + {1'b0, i_op.b ^ {cdo_pkg::W_ALU{i_op.sub}}}
                 + (cdo_pkg::W_ALU+1)'(i_op.sub);
    assign o_sum   = w_sum[cdo_pkg::W_ALU-1:0];
    assign o_carry = w_sum[cdo_pkg::W_ALU];

endmodule

// File: rtl/cdo_seq.sv
module cdo_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  cdo_pkg::t_req                 i_req,
    input  logic                          i_take,
    output cdo_pkg::t_seq_stat            o_stat,
    output cdo_pkg::t_res                 o_res,
    output cdo_pkg::t_alu_op              o_alu_op,
    input  logic [cdo_pkg::W_ALU-1:0]     i_alu_sum,
    input  logic                          i_alu_carry
);

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_CLAMP, S_INIT, S_WALK_UP, S_WALK_DN,
        S_DIV, S_MON, S_YEAR, S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [cdo_pkg::W_MODE-1:0]      r_mode, n_mode;
    logic [cdo_pkg::W_DAY-1:0]       r_d, n_d;
    logic [cdo_pkg::W_MONTH-1:0]     r_m, n_m;
    logic [cdo_pkg::W_YEAR-1:0]      r_y, n_y;
    logic [cdo_pkg::W_AMT-1:0]       r_amt, n_amt;
    logic [cdo_pkg::W_REM-1:0]       r_rem, n_rem;
    logic [cdo_pkg::W_ALU-1:0]       r_v, n_v;
    logic [cdo_pkg::W_STEP-1:0]      r_k, n_k;
    logic [cdo_pkg::W_QUO-1:0]       r_q, n_q;
    logic                            r_err, n_err;
    logic                            r_second, n_second;

    logic                            w_leap_cur;
    logic [cdo_pkg::W_DAY-1:0]       w_len_cur;
    logic [cdo_pkg::W_MONTH-1:0]     w_dn_m;
    logic [cdo_pkg::W_YEAR-1:0]      w_dn_y;
    logic [cdo_pkg::W_REM-1:0]       w_dn_rem;
    logic [cdo_pkg::W_DAY-1:0]       w_dn_len;
    logic [cdo_pkg::W_REM-1:0]       w_clamp_rem;
    logic [cdo_pkg::W_DAY-1:0]       w_clamp_len;
    logic [cdo_pkg::W_DAY-1:0]       w_mon_lo;
    logic                            w_is_add;
    logic                            w_is_month;

    assign w_is_add   = !r_mode[0];
    assign w_is_month = (r_mode == cdo_pkg::MODE_ADD_MONTHS)
                     || (r_mode == cdo_pkg::MODE_SUB_MONTHS);

    assign w_leap_cur = cdo_pkg::f_is_leap(r_y != cdo_pkg::C_YEAR_MIN, r_y[1:0], r_rem);
    assign w_len_cur  = cdo_pkg::f_month_len(r_m, w_leap_cur);

    // Month before the current one, with year and mod-400 borrow.
    always_comb begin
        if (r_m == cdo_pkg::M_JAN) begin
            w_dn_m   = cdo_pkg::M_DEC;
            w_dn_y   = r_y - cdo_pkg::W_YEAR'(1);
            w_dn_rem = (r_rem == '0) ? cdo_pkg::C_REM_LAST : r_rem - cdo_pkg::W_REM'(1);
        end else begin
            w_dn_m   = r_m - cdo_pkg::W_MONTH'(1);
            w_dn_y   = r_y;
            w_dn_rem = r_rem;
        end
    end

    assign w_dn_len = cdo_pkg::f_month_len(w_dn_m,
        cdo_pkg::f_is_leap(w_dn_y != cdo_pkg::C_YEAR_MIN, w_dn_y[1:0], w_dn_rem));

    assign w_clamp_rem = r_v[cdo_pkg::W_REM-1:0];
    assign w_clamp_len = cdo_pkg::f_month_len(r_m,
        cdo_pkg::f_is_leap(r_y != cdo_pkg::C_YEAR_MIN, r_y[1:0], w_clamp_rem));

    assign w_mon_lo = i_alu_sum[cdo_pkg::W_DAY-1:0];

    always_comb begin
        o_alu_op.a   = r_v;
        o_alu_op.b   = '0;
        o_alu_op.sub = 1'b0;
        case (r_state)
            S_RED: begin
                o_alu_op.b   = cdo_pkg::C_Y400 << r_k;
                o_alu_op.sub = 1'b1;
            end
            S_INIT: begin
                o_alu_op.a   = cdo_pkg::W_ALU'(r_d);
                o_alu_op.b   = cdo_pkg::W_ALU'(r_amt);
                o_alu_op.sub = !w_is_add;
            end
            S_WALK_UP: begin
                o_alu_op.b   = cdo_pkg::W_ALU'(w_len_cur);
                o_alu_op.sub = 1'b1;
            end
            S_WALK_DN: begin
                o_alu_op.b   = cdo_pkg::W_ALU'(w_dn_len);
            end
            S_DIV: begin
                o_alu_op.b   = cdo_pkg::C_M12 << r_k;
                o_alu_op.sub = 1'b1;
            end
            S_MON: begin
                o_alu_op.a   = cdo_pkg::W_ALU'(r_m - cdo_pkg::W_MONTH'(1));
                o_alu_op.b   = cdo_pkg::W_ALU'(r_v[cdo_pkg::W_MONTH-1:0]);
                o_alu_op.sub = !w_is_add;
            end
            S_YEAR: begin
                o_alu_op.a   = cdo_pkg::W_ALU'(r_y);
                o_alu_op.b   = w_is_month ? cdo_pkg::W_ALU'(r_q) : cdo_pkg::W_ALU'(r_amt);
                o_alu_op.sub = !w_is_add;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_d      = r_d;
        n_m      = r_m;
        n_y      = r_y;
        n_amt    = r_amt;
        n_rem    = r_rem;
        n_v      = r_v;
        n_k      = r_k;
        n_q      = r_q;
        n_err    = r_err;
        n_second = r_second;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode = i_req.mode;
                    if (i_req.month == '0) begin
                        n_m = cdo_pkg::M_JAN;
                    end else if (i_req.month > cdo_pkg::M_DEC) begin
                        n_m = cdo_pkg::M_DEC;
                    end else begin
                        n_m = i_req.month;
                    end
                    n_d      = (i_req.day == '0) ? cdo_pkg::C_DAY_FIRST : i_req.day;
                    n_y      = i_req.year;
                    n_amt    = (i_req.amount > cdo_pkg::C_MAX_SHIFT) ? cdo_pkg::C_MAX_SHIFT
                                                                     : i_req.amount;
                    n_v      = cdo_pkg::W_ALU'(i_req.year);
                    n_k      = cdo_pkg::C_RED_TOP;
                    n_err    = 1'b0;
                    n_second = 1'b0;
                    n_state  = S_RED;
                end
            end
            // Restoring reduction of the year mod 400, one shifted divisor per cycle.
            S_RED: begin
                if (i_alu_carry) begin
                    n_v = i_alu_sum;
                end
                if (r_k == '0) begin
                    n_state = S_CLAMP;
                end else begin
                    n_k = r_k - cdo_pkg::W_STEP'(1);
                end
            end
            S_CLAMP: begin
                n_rem = w_clamp_rem;
                if (r_d > w_clamp_len) begin
                    n_d = w_clamp_len;
                end
                if (r_second) begin
                    n_state = S_DONE;
                end else begin
                    case (r_mode)
                        cdo_pkg::MODE_ADD_DAYS, cdo_pkg::MODE_SUB_DAYS: begin
                            n_state = S_INIT;
                        end
                        cdo_pkg::MODE_ADD_MONTHS, cdo_pkg::MODE_SUB_MONTHS: begin
                            n_v     = cdo_pkg::W_ALU'(r_amt);
                            n_k     = cdo_pkg::C_DIV_TOP;
                            n_q     = '0;
                            n_state = S_DIV;
                        end
                        cdo_pkg::MODE_ADD_YEARS, cdo_pkg::MODE_SUB_YEARS: begin
                            n_state = S_YEAR;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                n_v     = i_alu_sum;
                n_state = w_is_add ? S_WALK_UP : S_WALK_DN;
            end
            // Remaining days exceed this month: drop its length and advance a month.
            S_WALK_UP: begin
                if (i_alu_carry && (i_alu_sum != '0)) begin
                    n_v = i_alu_sum;
                    if (r_m == cdo_pkg::M_DEC) begin
                        if (r_y == cdo_pkg::C_YEAR_MAX) begin
                            n_err   = 1'b1;
                            n_d     = cdo_pkg::C_DAY_LAST;
                            n_state = S_DONE;
                        end else begin
                            n_m   = cdo_pkg::M_JAN;
                            n_y   = r_y + cdo_pkg::W_YEAR'(1);
                            n_rem = (r_rem == cdo_pkg::C_REM_LAST) ? '0
                                                                   : r_rem + cdo_pkg::W_REM'(1);
                        end
                    end else begin
                        n_m = r_m + cdo_pkg::W_MONTH'(1);
                    end
                end else begin
                    n_d     = r_v[cdo_pkg::W_DAY-1:0];
                    n_state = S_DONE;
                end
            end
            // Day count below one: step back a month and add its length.
            S_WALK_DN: begin
                if (!r_v[cdo_pkg::W_ALU-1] && (r_v != '0)) begin
                    n_d     = r_v[cdo_pkg::W_DAY-1:0];
                    n_state = S_DONE;
                end else if ((r_m == cdo_pkg::M_JAN) && (r_y == cdo_pkg::C_YEAR_MIN)) begin
                    n_err   = 1'b1;
                    n_d     = cdo_pkg::C_DAY_FIRST;
                    n_state = S_DONE;
                end else begin
                    n_v   = i_alu_sum;
                    n_m   = w_dn_m;
                    n_y   = w_dn_y;
                    n_rem = w_dn_rem;
                end
            end
            // Amount / 12, restoring, one quotient bit per cycle.
            S_DIV: begin
                if (i_alu_carry) begin
                    n_v      = i_alu_sum;
                    n_q[r_k] = 1'b1;
                end
                if (r_k == '0) begin
                    n_state = S_MON;
                end else begin
                    n_k = r_k - cdo_pkg::W_STEP'(1);
                end
            end
            S_MON: begin
                if (w_is_add) begin
                    if (w_mon_lo >= cdo_pkg::C_MON_SPAN) begin
                        n_m = cdo_pkg::W_MONTH'(w_mon_lo - cdo_pkg::C_MON_SPAN) + cdo_pkg::M_JAN;
                        n_q = r_q + cdo_pkg::W_QUO'(1);
                    end else begin
                        n_m = cdo_pkg::W_MONTH'(w_mon_lo) + cdo_pkg::M_JAN;
                    end
                end else begin
                    if (i_alu_sum[cdo_pkg::W_ALU-1]) begin
                        n_m = cdo_pkg::W_MONTH'(w_mon_lo + cdo_pkg::C_MON_SPAN) + cdo_pkg::M_JAN;
                        n_q = r_q + cdo_pkg::W_QUO'(1);
                    end else begin
                        n_m = cdo_pkg::W_MONTH'(w_mon_lo) + cdo_pkg::M_JAN;
                    end
                end
                n_state = S_YEAR;
            end
            S_YEAR: begin
                n_k      = cdo_pkg::C_RED_TOP;
                n_second = 1'b1;
                n_state  = S_RED;
                n_y      = i_alu_sum[cdo_pkg::W_YEAR-1:0];
                n_v      = i_alu_sum;
                if (i_alu_sum[cdo_pkg::W_ALU-1]) begin
                    n_err = 1'b1;
                    n_y   = w_is_add ? cdo_pkg::C_YEAR_MAX : cdo_pkg::C_YEAR_MIN;
                    n_v   = cdo_pkg::W_ALU'(n_y);
                    if (w_is_month) begin
                        // Month shift out of range pins the whole date.
                        n_m     = w_is_add ? cdo_pkg::M_DEC : cdo_pkg::M_JAN;
                        n_d     = w_is_add ? cdo_pkg::C_DAY_LAST : cdo_pkg::C_DAY_FIRST;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mode   <= n_mode;
        r_d      <= n_d;
        r_m      <= n_m;
        r_y      <= n_y;
        r_amt    <= n_amt;
        r_rem    <= n_rem;
        r_v      <= n_v;
        r_k      <= n_k;
        r_q      <= n_q;
        r_err    <= n_err;
        r_second <= n_second;
    end

    // Error in a day walk pins the whole date to the range end.
    always_comb begin
        o_res.day   = r_d;
        o_res.month = r_m;
        o_res.year  = r_y;
        o_res.err   = r_err;
        if (r_err && !w_is_month && (r_mode[2:1] == 2'b00)) begin
            o_res.month = w_is_add ? cdo_pkg::M_DEC : cdo_pkg::M_JAN;
            o_res.year  = w_is_add ? cdo_pkg::C_YEAR_MAX : cdo_pkg::C_YEAR_MIN;
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);

endmodule

// File: rtl/calendar_date_offset_core.sv
// Gregorian date offset engine.
// Request channel i_req carries mode, day_in, month_in, year_in and amount;
// result channel o_res carries day_out, month_out, year_out and range_error.
// Both use valid/ready; a transfer happens when both are high at a clock edge.
// One request is worked at a time: i_req.ready is high only while the
// sequencer is idle and reset is released. A shared 17-bit add/subtract unit does the main sums.
// Each request first has its year reduced mod 400 and its day clamped to the
// month. Day shifts then walk the date one month boundary at a time; month
// shifts divide the amount by 12, restoring; year shifts go to the year sum.
// Month and year shifts then reduce the new year again and clamp the day;
// a month shift out of range pins the date instead. Modes 6 and 7 return
// the normalized input date.
// The result sits in an output register; a new request is taken while it
// waits, and the sequencer holds the next result until the register drains.
// Synchronous active-low reset returns the sequencer to idle and clears the output valid.
module calendar_date_offset_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdo_req_if.sink   i_req,
    cdo_res_if.source o_res
);

    cdo_pkg::t_req                 w_req;
    cdo_pkg::t_res                 w_res;
    cdo_pkg::t_seq_stat            w_stat;
    cdo_pkg::t_alu_op              w_alu_op;
    logic [cdo_pkg::W_ALU-1:0]     w_alu_sum;
    logic                          w_alu_carry;
    logic                          w_take;

    logic                          r_ovalid;
    cdo_pkg::t_res                 r_out;

    assign w_req.mode   = i_req.mode;
    assign w_req.day    = i_req.day_in;
    assign w_req.month  = i_req.month_in;
    assign w_req.year   = i_req.year_in;
    assign w_req.amount = i_req.amount;

    assign i_req.ready = w_stat.idle && i_rst_n;
    assign w_take      = !r_ovalid || o_res.ready;

    cdo_alu u_alu (
        .i_op    (w_alu_op),
        .o_sum   (w_alu_sum),
        .o_carry (w_alu_carry)
    );

    cdo_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req.valid),
        .i_req       (w_req),
        .i_take      (w_take),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_alu_op    (w_alu_op),
        .i_alu_sum   (w_alu_sum),
        .i_alu_carry (w_alu_carry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_stat.done && w_take) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_stat.done && w_take) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.day_out     = r_out.day;
    assign o_res.month_out   = r_out.month;
    assign o_res.year_out    = r_out.year;
    assign o_res.range_error = r_out.err;

endmodule

// File: rtl/cdo_checker.sv
`include "calendar_date_offset_core_assert.svh"

module cdo_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [cdo_pkg::W_DAY-1:0]     i_day,
    input logic [cdo_pkg::W_MONTH-1:0]   i_month,
    input logic [cdo_pkg::W_YEAR-1:0]    i_year,
    input logic                          i_err
);

    // A stalled result keeps its payload.
    `CDO_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_day) && $stable(i_month) && $stable(i_year) && $stable(i_err))

    // A taken request makes the block busy.
    `CDO_ASSERT_NEXT(a_busy_after_req, i_req_valid && i_req_ready, !i_req_ready)

    // Saturation only shows at a range end.
    `CDO_ASSERT_SAME(a_err_at_bound, i_res_valid && i_err, (i_year == cdo_pkg::C_YEAR_MAX) || (i_year == cdo_pkg::C_YEAR_MIN))

    // Result date is well formed.
    `CDO_ASSERT_SAME(a_date_legal, i_res_valid, (i_month >= cdo_pkg::M_JAN) && (i_month <= cdo_pkg::M_DEC) && (i_day != '0) && ((i_month != cdo_pkg::M_FEB) || (i_day <= 5'd29)))

endmodule

bind calendar_date_offset_core cdo_checker u_cdo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_day       (o_res.day_out),
    .i_month     (o_res.month_out),
    .i_year      (o_res.year_out),
    .i_err       (o_res.range_error)
);

// File: tb/calendar_date_offset_core_tb.sv
`timescale 1ns / 1ps

module calendar_date_offset_core_tb;

    // Modes with no operation behind them: the core returns the cleaned-up start date
    localparam logic [cdo_pkg::W_MODE-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [cdo_pkg::W_MODE-1:0] MODE_SPARE_7 = 3'd7;

    localparam int unsigned YEAR_TOP    = 65535;
    localparam int unsigned DRAIN_TICKS = 200;

    typedef struct {
        cdo_pkg::t_req req;
        bit            known;
        cdo_pkg::t_res want;
    } t_vector;

    logic i_clk;
    logic i_rst_n;

    cdo_req_if req_bus ();
    cdo_res_if res_bus ();

    calendar_date_offset_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    cdo_pkg::t_res due_dates[$];
    t_vector       vectors[$];
    cdo_pkg::t_res got_date;
    cdo_pkg::t_res want_date;
    int            bad_count;
    int            src_idle_pct;
    int            sink_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("calendar_date_offset_core_tb: FAIL");
        $finish;
    end

    function automatic bit leap_year(input int unsigned y);
        if (y == 0) return 1'b0;
        if (y % 400 == 0) return 1'b1;
        if (y % 100 == 0) return 1'b0;
        return (y % 4 == 0);
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        if (m == cdo_pkg::M_FEB) return leap_year(y) ? 29 : 28;
        if (m == cdo_pkg::M_APR || m == cdo_pkg::M_JUN ||
            m == cdo_pkg::M_SEP || m == cdo_pkg::M_NOV) return 30;
        return 31;
    endfunction

    function automatic cdo_pkg::t_res shift_date(input cdo_pkg::t_req r);
        cdo_pkg::t_res o;
        int unsigned   d;
        int unsigned   m;
        int unsigned   y;
        int unsigned   amt;
        int            dd;
        int            tot;
        bit            hi_sat;
        bit            lo_sat;
        bit            err;

        amt = r.amount;
        if (amt > cdo_pkg::MAX_SHIFT) amt = cdo_pkg::MAX_SHIFT;
        m = r.month;
        if (m < cdo_pkg::M_JAN) m = cdo_pkg::M_JAN;
        if (m > cdo_pkg::M_DEC) m = cdo_pkg::M_DEC;
        y = r.year;
        d = r.day;
        if (d < 1) d = 1;
        if (d > days_in(m, y)) d = days_in(m, y);
        hi_sat = 1'b0;
        lo_sat = 1'b0;
        err    = 1'b0;

        case (r.mode)
            cdo_pkg::MODE_ADD_DAYS: begin
                dd = int'(d + amt);
                while (!hi_sat && dd > int'(days_in(m, y))) begin
                    dd -= int'(days_in(m, y));
                    if (m == cdo_pkg::M_DEC) begin
                        if (y == YEAR_TOP) begin
                            hi_sat = 1'b1;
                        end else begin
                            m = cdo_pkg::M_JAN;
                            y++;
                        end
                    end else begin
                        m++;
                    end
                end
                if (!hi_sat) d = dd;
            end
            cdo_pkg::MODE_SUB_DAYS: begin
                dd = int'(d) - int'(amt);
                while (!lo_sat && dd < 1) begin
                    if (m == cdo_pkg::M_JAN) begin
                        if (y == 0) begin
                            lo_sat = 1'b1;
                        end else begin
                            m = cdo_pkg::M_DEC;
                            y--;
                            dd += int'(days_in(m, y));
                        end
                    end else begin
                        m--;
                        dd += int'(days_in(m, y));
                    end
                end
                if (!lo_sat) d = dd;
            end
            cdo_pkg::MODE_ADD_MONTHS, cdo_pkg::MODE_SUB_MONTHS: begin
                tot = int'(y) * 12 + int'(m) - 1;
                if (r.mode == cdo_pkg::MODE_ADD_MONTHS) tot += int'(amt);
                else tot -= int'(amt);
                if (tot < 0) begin
                    lo_sat = 1'b1;
                end else if (tot / 12 > YEAR_TOP) begin
                    hi_sat = 1'b1;
                end else begin
                    y = tot / 12;
                    m = tot % 12 + 1;
                    if (d > days_in(m, y)) d = days_in(m, y);
                end
            end
            cdo_pkg::MODE_ADD_YEARS, cdo_pkg::MODE_SUB_YEARS: begin
                if (r.mode == cdo_pkg::MODE_ADD_YEARS) begin
                    if (y + amt > YEAR_TOP) begin
                        y   = YEAR_TOP;
                        err = 1'b1;
                    end else begin
                        y += amt;
                    end
                end else begin
                    if (amt > y) begin
                        y   = 0;
                        err = 1'b1;
                    end else begin
                        y -= amt;
                    end
                end
                if (d > days_in(m, y)) d = days_in(m, y);
            end
            default: begin
            end
        endcase

        // Day and month shifts that run off either end pin to the first or last date
        if (hi_sat) begin
            d = 31;
            m = cdo_pkg::M_DEC;
            y = YEAR_TOP;
            err = 1'b1;
        end
        if (lo_sat) begin
            d = 1;
            m = cdo_pkg::M_JAN;
            y = 0;
            err = 1'b1;
        end
        o.day   = cdo_pkg::W_DAY'(d);
        o.month = cdo_pkg::W_MONTH'(m);
        o.year  = cdo_pkg::W_YEAR'(y);
        o.err   = err;
        return o;
    endfunction

    function automatic cdo_pkg::t_req random_request();
        cdo_pkg::t_req r;
        r.mode  = ($urandom_range(15) == 0) ? cdo_pkg::W_MODE'($urandom_range(7, 6))
                                            : cdo_pkg::W_MODE'($urandom_range(5, 0));
        r.day   = ($urandom_range(9) == 0) ? cdo_pkg::W_DAY'($urandom())
                                           : cdo_pkg::W_DAY'($urandom_range(31, 1));
        r.month = ($urandom_range(9) == 0) ? cdo_pkg::W_MONTH'($urandom())
                                           : cdo_pkg::W_MONTH'($urandom_range(12, 1));
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(7))
                    0: r.year = 16'd0;
                    1: r.year = 16'd4;
                    2: r.year = 16'd100;
                    3: r.year = 16'd400;
                    4: r.year = 16'd1900;
                    5: r.year = 16'd2000;
                    6: r.year = 16'd2100;
                    default: r.year = 16'd65532;
                endcase
            end
            1: r.year = cdo_pkg::W_YEAR'($urandom_range(15, 0));
            2: r.year = cdo_pkg::W_YEAR'($urandom_range(65535, 65520));
            3: r.year = cdo_pkg::W_YEAR'($urandom_range(400, 0));
            4: r.year = cdo_pkg::W_YEAR'($urandom_range(65535, 65100));
            default: r.year = cdo_pkg::W_YEAR'($urandom());
        endcase
        case ($urandom_range(4))
            0: r.amount = cdo_pkg::W_AMT'($urandom_range(40, 0));
            1: r.amount = cdo_pkg::C_MAX_SHIFT - cdo_pkg::W_AMT'($urandom_range(3, 0));
            default: r.amount = cdo_pkg::W_AMT'($urandom());
        endcase
        return r;
    endfunction

    task automatic check_row(input logic [cdo_pkg::W_MODE-1:0] mode, input int unsigned d,
                             input int unsigned m, input int unsigned y,
                             input int unsigned amt);
        t_vector v;
        v.req.mode   = mode;
        v.req.day    = cdo_pkg::W_DAY'(d);
        v.req.month  = cdo_pkg::W_MONTH'(m);
        v.req.year   = cdo_pkg::W_YEAR'(y);
        v.req.amount = cdo_pkg::W_AMT'(amt);
        v.known      = 1'b0;
        v.want       = '0;
        vectors.push_back(v);
    endtask

    task automatic known_row(input logic [cdo_pkg::W_MODE-1:0] mode, input int unsigned d,
                             input int unsigned m, input int unsigned y,
                             input int unsigned amt, input int unsigned wd,
                             input int unsigned wm, input int unsigned wy,
                             input bit werr);
        check_row(mode, d, m, y, amt);
        vectors[$].known      = 1'b1;
        vectors[$].want.day   = cdo_pkg::W_DAY'(wd);
        vectors[$].want.month = cdo_pkg::W_MONTH'(wm);
        vectors[$].want.year  = cdo_pkg::W_YEAR'(wy);
        vectors[$].want.err   = werr;
    endtask

    // Present one request, hold it until taken, then queue its result
    task automatic push_request(input cdo_pkg::t_req r, input cdo_pkg::t_res want);
        if ($urandom_range(99) < src_idle_pct) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_bus.valid    <= 1'b1;
        req_bus.mode     <= r.mode;
        req_bus.day_in   <= r.day;
        req_bus.month_in <= r.month;
        req_bus.year_in  <= r.year;
        req_bus.amount   <= r.amount;
        do @(posedge i_clk); while (!req_bus.ready);
        due_dates.push_back(want);
    endtask

    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got_date.day   = res_bus.day_out;
            got_date.month = res_bus.month_out;
            got_date.year  = res_bus.year_out;
            got_date.err   = res_bus.range_error;
            if (due_dates.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: unexpected result %0d/%0d/%0d err=%0b", $realtime,
                             got_date.day, got_date.month, got_date.year, got_date.err);
            end else begin
                want_date = due_dates.pop_front();
                if (got_date.day !== want_date.day || got_date.month !== want_date.month ||
                    got_date.year !== want_date.year || got_date.err !== want_date.err) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: mismatch exp %0d/%0d/%0d err=%0b got %0d/%0d/%0d err=%0b",
                                 $realtime, want_date.day, want_date.month, want_date.year,
                                 want_date.err, got_date.day, got_date.month, got_date.year,
                                 got_date.err);
                end
            end
        end
    end

    initial begin
        cdo_pkg::t_req fresh_req;

        bad_count      = 0;
        src_idle_pct   = 32;
        sink_stall_pct = 74;
        i_rst_n          <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.mode     <= cdo_pkg::MODE_ADD_DAYS;
        req_bus.day_in   <= '0;
        req_bus.month_in <= '0;
        req_bus.year_in  <= '0;
        req_bus.amount   <= '0;

        known_row(cdo_pkg::MODE_ADD_DAYS, 15, 6, 2024, 0, 15, 6, 2024, 0);
        known_row(cdo_pkg::MODE_ADD_DAYS, 31, 12, 65535, 4095, 31, 12, 65535, 1);
        known_row(cdo_pkg::MODE_SUB_DAYS, 1, 1, 0, 4095, 1, 1, 0, 1);
        known_row(cdo_pkg::MODE_ADD_MONTHS, 1, 1, 65535, 4095, 31, 12, 65535, 1);
        known_row(cdo_pkg::MODE_SUB_MONTHS, 1, 1, 0, 1, 1, 1, 0, 1);
        known_row(cdo_pkg::MODE_ADD_YEARS, 10, 3, 65535, 1, 10, 3, 65535, 1);
        // Year zero is not leap, so the day is clamped before the year saturates
        known_row(cdo_pkg::MODE_SUB_YEARS, 29, 2, 0, 1, 28, 2, 0, 1);
        known_row(cdo_pkg::MODE_ADD_YEARS, 29, 2, 2024, 1, 28, 2, 2025, 0);
        known_row(cdo_pkg::MODE_SUB_YEARS, 15, 7, 4095, 4095, 15, 7, 0, 0);
        known_row(MODE_SPARE_6, 0, 0, 2000, 0, 1, 1, 2000, 0);
        known_row(MODE_SPARE_7, 31, 15, 1900, 4095, 31, 12, 1900, 0);
        known_row(MODE_SPARE_6, 31, 4, 2023, 7, 30, 4, 2023, 0);
        known_row(MODE_SPARE_7, 30, 2, 2000, 0, 29, 2, 2000, 0);
        known_row(cdo_pkg::MODE_SUB_MONTHS, 0, 0, 1, 0, 1, 1, 1, 0);
        known_row(cdo_pkg::MODE_ADD_MONTHS, 31, 1, 1900, 1, 28, 2, 1900, 0);
        known_row(cdo_pkg::MODE_SUB_DAYS, 1, 3, 2000, 1, 29, 2, 2000, 0);
        known_row(cdo_pkg::MODE_ADD_DAYS, 28, 2, 1900, 1, 1, 3, 1900, 0);
        check_row(cdo_pkg::MODE_ADD_YEARS, 29, 2, 2096, 4);
        check_row(cdo_pkg::MODE_SUB_MONTHS, 31, 3, 2001, 13);
        check_row(cdo_pkg::MODE_ADD_DAYS, 1, 1, 0, 365);
        check_row(cdo_pkg::MODE_ADD_DAYS, 1, 1, 2000, 4095);
        check_row(cdo_pkg::MODE_SUB_DAYS, 31, 12, 65535, 4095);
        check_row(cdo_pkg::MODE_SUB_MONTHS, 1, 1, 341, 4095);
        check_row(cdo_pkg::MODE_ADD_MONTHS, 31, 12, 65534, 12);
        check_row(cdo_pkg::MODE_ADD_YEARS, 31, 2, 65535, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vectors[i])
            push_request(vectors[i].req,
                         vectors[i].known ? vectors[i].want : shift_date(vectors[i].req));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 32;
                    sink_stall_pct = 74;
                end
                1: begin
                    src_idle_pct   = 74;
                    sink_stall_pct = 32;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < 250; n++) begin
                fresh_req = random_request();
                push_request(fresh_req, shift_date(fresh_req));
            end
        end
        req_bus.valid <= 1'b0;

        while (due_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        if (bad_count == 0 && due_dates.size() == 0) begin
            $display("calendar_date_offset_core_tb: PASS");
        end else begin
            $display("calendar_date_offset_core_tb: FAIL");
        end
        $finish;
    end

endmodule
